### hw/rtl/ibfr_pkg.sv
// ----------------------------------------------------------------------------
// ibfr_pkg
// Shared types and constants of the bus frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ibfr_pkg;

    // Frame buffer geometry
    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    // Frame layout and completion rules
    localparam logic [CNT_W-1:0] LEN_POS   = CNT_W'(1);
    localparam logic [8:0]       LEN_EXTRA = 9'd2;
    localparam logic [CNT_W-1:0] MIN_HELD  = CNT_W'(3);

    // Configuration register
    localparam logic [15:0] GAP_RESET = 16'd50;
    localparam logic        REG_GAP   = 1'b0;   // register index bit of paddr

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_CMP,
        ST_ERD,
        ST_OUT
    } t_state;

    // Frame buffer access request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

### hw/rtl/ibfr_ram.sv
// ----------------------------------------------------------------------------
// ibfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/ibfr_cfg.sv
// ----------------------------------------------------------------------------
// ibfr_cfg
// APB register block holding the inter-byte gap limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfr_cfg
    import ibfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [15:0] o_gap_limit
);

    logic [15:0] r_gap_limit;
    logic        wr_gap;

    // Write strobe on the access phase
    assign wr_gap = psel && penable && pwrite && (paddr[2] == REG_GAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= GAP_RESET;
        end else if (wr_gap) begin
            r_gap_limit <= pwdata[15:0];
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_GAP) begin
            prdata = {16'd0, r_gap_limit};
        end
    end

    assign pready      = 1'b1;
    assign o_gap_limit = r_gap_limit;

endmodule

`default_nettype wire

### hw/rtl/ibfr_ctrl.sv
// ----------------------------------------------------------------------------
// ibfr_ctrl
// Sequencer: frame assembly, XOR checksum pass over the buffer, and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfr_ctrl
    import ibfr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [15:0]       i_gap_limit,
    // incoming bytes
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [31:0]       i_time_ms,
    // verified frame bytes
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [7:0]        o_frame_byte,
    output logic      [ADDR_W-1:0] o_byte_index,
    output logic                   o_frame_last,
    // frame buffer
    output t_mem_req               o_mem,
    input  wire logic [7:0]        i_mem_q
);

    t_state            r_state, n_state;
    logic [7:0]        r_byte;
    logic [31:0]       r_time;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [31:0]       r_last_t, n_last_t;
    logic [7:0]        r_len, n_len;
    logic [ADDR_W-1:0] r_last_idx, n_last_idx;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [7:0]        r_x, n_x;

    logic [31:0]       gap;
    logic              restart;
    logic [CNT_W-1:0]  held_inc;
    logic [8:0]        total;
    logic              at_last;

    // Gap since the previous byte, modulo 2^32
    assign gap      = r_time - r_last_t;
    assign restart  = (r_held == '0) || (gap > {16'd0, i_gap_limit});
    assign held_inc = r_held + CNT_W'(1);
    assign total    = {1'b0, r_len} + LEN_EXTRA;
    assign at_last  = (r_k == r_last_idx);

    // Input capture
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_byte <= i_rx_byte;
            r_time <= i_time_ms;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_last_t <= '0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_last_t <= n_last_t;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_last_idx <= n_last_idx;
        r_k        <= n_k;
        r_x        <= n_x;
    end

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_last_t    = r_last_t;
        n_len       = r_len;
        n_last_idx  = r_last_idx;
        n_k         = r_k;
        n_x         = r_x;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_mem       = '0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end

            // Place the byte and decide whether the frame is complete
            ST_CHECK: begin
                n_state  = ST_IDLE;
                n_last_t = r_time;
                if (restart) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = '0;
                    o_mem.wdata = r_byte;
                    n_held      = CNT_W'(1);
                end else if (r_held >= CNT_W'(MAX_FRAME)) begin
                    // buffer overflow: drop frame and byte
                    n_held = '0;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_held[ADDR_W-1:0];
                    o_mem.wdata = r_byte;
                    n_held      = held_inc;
                    if (r_held == LEN_POS) begin
                        n_len = r_byte;
                    end
                    if (held_inc >= MIN_HELD && {2'b0, held_inc} >= total) begin
                        n_held     = '0;
                        n_last_idx = ADDR_W'(total - 9'd1);
                        n_k        = '0;
                        n_x        = '0;
                        n_state    = ST_SUM;
                    end
                end
            end

            // XOR all bytes before the checksum, one read per cycle
            ST_SUM: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_k;
                if (r_k != '0) begin
                    n_x = r_x ^ i_mem_q;
                end
                if (at_last) begin
                    n_state = ST_CMP;
                end else begin
                    n_k = r_k + ADDR_W'(1);
                end
            end

            // Checksum byte is on the read port now
            ST_CMP: begin
                n_k = '0;
                if (r_x == i_mem_q) begin
                    n_state = ST_ERD;
                end else begin
                    n_state = ST_IDLE;
                end
            end

            ST_ERD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_k;
                n_state     = ST_OUT;
            end

            // Stream the frame, prefetching the next byte on each handshake
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k         = r_k + ADDR_W'(1);
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_k + ADDR_W'(1);
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_frame_byte = i_mem_q;
    assign o_byte_index = r_k;
    assign o_frame_last = at_last;

endmodule

`default_nettype wire

### hw/rtl/ibus_frame_receiver.sv
// ----------------------------------------------------------------------------
// ibus_frame_receiver
// Collects time-stamped bus bytes into frames and emits frames whose XOR
// checksum matches.
// ----------------------------------------------------------------------------
// One byte at a time is taken: a byte that does not complete a frame is
// captured, then gap-checked and written to the buffer. A byte that completes
// a frame of N bytes (N = length byte + 2) adds a checksum pass, which reads
// the 64-byte frame buffer once per cycle through a single XOR accumulator,
// then a compare step; a good frame then needs a prefetch read and streams
// its N bytes at one per cycle, each waiting on m_axis_tready. s_axis_tready
// is high only while the block is idle, so no new byte is taken until a
// completed frame has been checked and streamed out. The frame buffer needs
// no clear after reset. tdata packs the fields from bit 0 up.
// ----------------------------------------------------------------------------
`default_nettype none

module ibus_frame_receiver
    import ibfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // rx_byte[7:0], time_ms[39:8]
    // verified frames
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // frame_byte[7:0], byte_index[13:8], zeros
    output logic             m_axis_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [15:0]       gap_limit;
    t_mem_req          mem;
    logic [7:0]        mem_q;
    logic [7:0]        frame_byte;
    logic [ADDR_W-1:0] byte_index;

    ibfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_gap_limit (gap_limit)
    );

    ibfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gap_limit  (gap_limit),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_rx_byte    (s_axis_tdata[7:0]),
        .i_time_ms    (s_axis_tdata[39:8]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_frame_byte (frame_byte),
        .o_byte_index (byte_index),
        .o_frame_last (m_axis_tlast),
        .o_mem        (mem),
        .i_mem_q      (mem_q)
    );

    ibfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (mem_q)
    );

    assign m_axis_tdata = {2'b00, byte_index, frame_byte};

endmodule

`default_nettype wire

### hw/rtl/ibfr_checker.sv
// ----------------------------------------------------------------------------
// ibfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Input side and output side are never open together
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a frame item is offered");

    // An accepted byte keeps the block busy for the next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // A stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output item changed while stalled");

    // Frame bytes follow back to back with rising index
    a_next_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tdata[13:8] == $past(m_axis_tdata[13:8]) + 6'd1))
        else $error("frame readout broken");

    // Frame ends after the last item
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("output still valid after last item");

endmodule

bind ibus_frame_receiver ibfr_checker u_ibfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### dv/tb_ibus_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ibus_frame_receiver
// Self-checking bench for the bus frame receiver. Time-stamped bytes are
// streamed in as whole frames with random content, broken frames and noise.
// A cycle-free model of the frame buffer predicts every verified frame byte,
// and each output item is checked against it in order. Gap limit settings and
// idling of both stream sides change from one phase to the next.
// ----------------------------------------------------------------------------
module tb_ibus_frame_receiver;
    import ibfr_pkg::*;

    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         SETTLE_CYCLES = 200;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 40;
    localparam logic [2:0] GAP_ADDR      = 3'd0;

    typedef enum {SEQ_GOOD, SEQ_BAD, SEQ_CUT} t_seq_kind;

    typedef struct packed {
        logic [31:0] stamp_ms;
        logic [7:0]  data;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] value;
        logic [5:0] index;
        logic       last_flag;
    } t_frame_out;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // rx_byte[7:0], time_ms[39:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // frame_byte[7:0], byte_index[13:8], zeros
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Frame buffer model
    logic [7:0]  model_store [MAX_FRAME];
    int          model_held    = 0;
    logic [31:0] model_last_ms = '0;
    logic [15:0] model_gap     = GAP_RESET;
    t_frame_out  good_frame_bytes [$];

    // Stimulus state
    t_rx_item    rx_pending [$];
    bit          rx_fire        = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [31:0] gen_ms         = '0;
    logic [15:0] gen_gap        = GAP_RESET;
    bit          gen_dirty      = 1'b0;
    int          gen_count      = 0;
    int          errors         = 0;
    int          cycles         = 0;

    ibus_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Predict the verified frame bytes caused by one accepted byte
    function automatic void track_rx_byte(input logic [7:0] b, input logic [31:0] t);
        logic [31:0] gap_seen;
        logic [7:0]  sum;
        int          total;
        gap_seen = t - model_last_ms;
        if (model_held == 0 || gap_seen > {16'd0, model_gap}) begin
            // empty buffer or gap too long: byte opens a new frame
            model_store[0] = b;
            model_held     = 1;
            model_last_ms  = t;
            return;
        end
        model_last_ms = t;
        if (model_held >= MAX_FRAME) begin
            // buffer full: frame lost, byte dropped
            model_held = 0;
            return;
        end
        model_store[model_held] = b;
        model_held++;
        if (model_held < 3)
            return;
        total = int'(model_store[1]) + 2;
        if (model_held < total)
            return;
        model_held = 0;
        sum = '0;
        for (int k = 0; k < total - 1; k++)
            sum ^= model_store[k];
        if (sum != model_store[total-1])
            return;
        for (int k = 0; k < total; k++)
            good_frame_bytes.push_back('{value: model_store[k], index: 6'(k),
                                         last_flag: (k == total - 1)});
    endfunction

    // Monitor: config writes, accepted bytes and frame output check
    always @(posedge i_clk) begin
        t_frame_out want;
        rx_fire = 1'b0;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == GAP_ADDR)
                model_gap = pwdata[15:0];
            if (s_axis_tvalid && s_axis_tready) begin
                rx_fire = 1'b1;
                track_rx_byte(s_axis_tdata[7:0], s_axis_tdata[39:8]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (good_frame_bytes.size() == 0) begin
                    $display("%0t: unexpected output: byte %h idx %0d last %0d", $time,
                             m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
                    errors++;
                end else begin
                    want = good_frame_bytes.pop_front();
                    if (m_axis_tdata[7:0] !== want.value || m_axis_tdata[13:8] !== want.index
                            || m_axis_tlast !== want.last_flag) begin
                        $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d (byte/idx/last)",
                                 $time, want.value, want.index, want.last_flag,
                                 m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver: byte stream and output backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!s_axis_tvalid || rx_fire) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tdata  <= rx_pending.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic [31:0] delta);
        t_rx_item item;
        gen_ms        = gen_ms + delta;
        item.data     = b;
        item.stamp_ms = gen_ms;
        rx_pending.push_back(item);
        gen_count++;
    endtask

    // Gap between bytes of one frame, never above the limit
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return {16'd0, gen_gap};
            2:       return $urandom_range(0, gen_gap);
            default: return (gen_gap < 3) ? {16'd0, gen_gap} : $urandom_range(1, 3);
        endcase
    endfunction

    // Gap ahead of a frame; past the limit when bytes may still be held
    function automatic logic [31:0] pick_lead();
        if ($urandom_range(0, 15) == 0)
            return $urandom();
        if (gen_dirty)
            return gen_gap + 1 + $urandom_range(0, 100);
        return $urandom_range(0, 100);
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 62) : $urandom_range(0, 8);
    endfunction

    // One frame; step < 0 picks random in-limit gaps
    task automatic add_frame(input int len, input t_seq_kind kind, input logic [31:0] lead,
                             input int step);
        logic [7:0] fb [$];
        logic [7:0] sum;
        int         total;
        int         n;
        total = len + 2;
        n     = (total > MAX_FRAME) ? MAX_FRAME + 1 : total;
        for (int k = 0; k < n; k++)
            fb.push_back(8'($urandom_range(0, 255)));
        fb[1] = 8'(len);
        if (total == 2) begin
            // length byte doubles as checksum; a third byte closes the check
            fb[0] = (kind == SEQ_BAD) ? 8'($urandom_range(1, 255)) : 8'h00;
            fb.push_back(8'($urandom_range(0, 255)));
        end else if (total <= MAX_FRAME) begin
            sum = '0;
            for (int k = 0; k < total - 1; k++)
                sum ^= fb[k];
            fb[total-1] = (kind == SEQ_BAD) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        end
        n = (kind == SEQ_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int k = 0; k < n; k++)
            add_byte(fb[k], (k == 0) ? lead : ((step < 0) ? pick_step() : 32'(step)));
        gen_dirty = (kind == SEQ_CUT);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            add_byte(8'($urandom_range(0, 255)),
                     ($urandom_range(0, 3) == 0) ? $urandom() : pick_step());
        gen_dirty = 1'b1;
    endtask

    // Wait for the stream to empty and all frames to come out
    task automatic drain();
        while (rx_pending.size() != 0 || s_axis_tvalid || good_frame_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int mode, input logic [15:0] gap, input bit with_big);
        int start;
        int r;
        apb_write(GAP_ADDR, {16'd0, gap});
        gen_gap = gap;
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
        start = gen_count;
        if (with_big) begin
            // longest good frame, then one whose length can never fit
            add_frame(MAX_FRAME - 2, SEQ_GOOD, pick_lead(), -1);
            add_frame(MAX_FRAME - 1, SEQ_GOOD, pick_lead(), -1);
        end
        while (gen_count - start < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_frame(pick_len(), SEQ_GOOD, pick_lead(), -1);
            else if (r < 72)
                add_frame(pick_len(), SEQ_BAD, pick_lead(), -1);
            else if (r < 80)
                add_frame(pick_len(), SEQ_CUT, pick_lead(), -1);
            else if (r < 88)
                add_noise();
            else if (r < 94)
                add_frame($urandom_range(MAX_FRAME - 1, 255), SEQ_GOOD, pick_lead(), -1);
            else
                add_frame(0, SEQ_GOOD, pick_lead(), -1);
        end
        drain();
    endtask

    initial begin
        logic [15:0] gap_plan [PHASES];
        gap_plan = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 65534)),
                     16'd50, 16'hFFFF, 16'd0, 16'($urandom_range(2, 1000))};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset gap limit
        add_byte(8'h00, 32'd0);                 // length 0, good two-byte frame
        add_byte(8'h00, 32'd1);
        add_byte(8'hFF, 32'd1);
        add_byte(8'h5A, 32'd1);                 // length 0, failed check
        add_byte(8'h00, 32'd1);
        add_byte(8'h11, 32'd1);
        gen_ms = 32'hFFFF_FFFD;                 // time stamps wrap inside a frame
        add_frame(3, SEQ_GOOD, 32'd1, 1);
        add_frame(1, SEQ_GOOD, 32'd7, 50);      // every in-frame gap right at the limit
        add_byte(8'h12, 32'd3);                 // partial frame ...
        add_byte(8'h05, 32'd50);
        gen_dirty = 1'b1;
        add_frame(2, SEQ_GOOD, 32'd51, 1);      // ... lost to a gap one past the limit
        add_frame(2, SEQ_BAD, 32'd1, -1);
        drain();

        // Random phases
        for (int p = 0; p < PHASES; p++)
            run_phase(p % 4, gap_plan[p], p == 0);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
